/* hw/rtl/fbpa_pkg.sv */
// Shared types and constants for the fixed block pool allocator.
// Holds pool sizing, field widths, CSR addresses, command and status codes, and the control states.
// Depends on nothing; imported by the allocator top level.
package fbpa_pkg;

   localparam int NUM_BLOCKS = 256;
   localparam int IDX_W      = $clog2(NUM_BLOCKS);
   localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
   localparam int CFG_W      = 9;
   localparam int CSR_ADDR_W = 2;
   localparam int RSP_DATA_W = 48;

   localparam logic [CNT_W-1:0] POOL_SIZE = CNT_W'(NUM_BLOCKS);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_BLOCKS - 1);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MAX_ALLOC      = 2'd0,
      CSR_GENERAL_BLOCKS = 2'd1,
      CSR_RESERVE_BLOCKS = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_addr_type;

   typedef enum logic [1:0] {
      CMD_INIT    = 2'd0,
      CMD_ALLOC   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_LIMIT       = 2'd1,
      ST_EMPTY       = 2'd2,
      ST_BAD_RELEASE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_FINISH
   } state_type;

endpackage

/* hw/rtl/fbpa_ram.sv */
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// Read data holds its value until the next read enable.
// Depends on nothing.
module fbpa_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/fixed_block_pool_allocator.sv */
// Fixed block pool allocator top level: control, list pointers, counters and result register.
// Depends on fbpa_pkg and on fbpa_ram, which holds the next-block link of every block.
//
// The allocator hands out indices of fixed-size blocks from two FIFO free lists kept as
// linked lists in a 256-entry link memory: a general list, and a reserve list that only
// interrupt-context allocate requests may draw from once the general list is empty. An
// init request rebuilds both lists from the configuration with the highest index of each
// region at the head; it sweeps the link memory one entry per cycle before loading the
// result. Allocate, release and no-op requests issue the one link-memory read that an
// allocate needs in the accepting cycle; the finish state then updates the pointers, writes
// the link of a release and loads the result once the output register is free.
// One request is in flight at a time; a new request is taken as soon as
// the previous result has been loaded into the output register, even while that result
// still waits for the consumer. Configuration registers may be written at any time, but
// only while no request is in flight do they take effect predictably: max_alloc applies at
// once, the two region sizes at the next init. Before the first init both lists are empty.
module fixed_block_pool_allocator
   import fbpa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] block_index
   input  logic [2:0]            req_tuser,   // [1:0] command, [2] in_interrupt

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] granted_block, [8] unlimited, [17:9] available, [26:18] allocated_count,
   // [35:27] free_general, [44:36] free_reserve, [47:45] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,   // [1:0] status

   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   // Configuration registers.
   logic [CFG_W-1:0] max_alloc_ff, max_alloc_in;
   logic [CFG_W-1:0] general_cfg_ff, general_cfg_in;
   logic [CFG_W-1:0] reserve_cfg_ff, reserve_cfg_in;

   // Control state and the request being served.
   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic             irq_ff, irq_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;

   // List pointers and counters.
   logic [IDX_W-1:0] gen_head_ff, gen_head_in;
   logic [IDX_W-1:0] gen_tail_ff, gen_tail_in;
   logic [CNT_W-1:0] gen_cnt_ff, gen_cnt_in;
   logic [IDX_W-1:0] res_head_ff, res_head_in;
   logic [IDX_W-1:0] res_tail_ff, res_tail_in;
   logic [CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic [CNT_W-1:0] alloc_cnt_ff, alloc_cnt_in;
   logic [CNT_W-1:0] lat_reserve_ff, lat_reserve_in;
   logic [CNT_W-1:0] lat_total_ff, lat_total_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_user_ff, rsp_user_in;

   // Link memory ports.
   logic             link_we;
   logic [IDX_W-1:0] link_waddr;
   logic [IDX_W-1:0] link_wdata;
   logic             link_re;
   logic [IDX_W-1:0] link_raddr;
   logic [IDX_W-1:0] link_rdata;

   logic             req_accept;
   logic             out_free;
   logic [CNT_W-1:0] res_eff;
   logic [CNT_W-1:0] gen_room;
   logic [CNT_W-1:0] gen_eff;
   logic [CNT_W-1:0] total_eff;
   logic [CNT_W-1:0] max_ext;
   logic             limited;
   status_type       status;
   logic [IDX_W-1:0] granted;
   logic [CNT_W-1:0] avail;

   fbpa_ram #(
      .DATA_W (IDX_W),
      .DEPTH  (NUM_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // The allocate read is issued on acceptance: the general head if that list holds a
   // block, otherwise the reserve head. The data is only used when the list holds two or
   // more blocks, so a speculative read for other requests is harmless.
   assign link_re    = req_accept;
   assign link_raddr = (gen_cnt_ff != '0) ? gen_head_ff : res_head_ff;

   // Region sizes as an init would set them: the reserve is clamped to the pool, and the
   // general region to whatever the reserve leaves.
   assign res_eff   = (CNT_W'(reserve_cfg_ff) > POOL_SIZE) ? POOL_SIZE : CNT_W'(reserve_cfg_ff);
   assign gen_room  = POOL_SIZE - res_eff;
   assign gen_eff   = (CNT_W'(general_cfg_ff) > gen_room) ? gen_room : CNT_W'(general_cfg_ff);
   assign total_eff = res_eff + gen_eff;

   assign max_ext = CNT_W'(max_alloc_ff);
   assign limited = (max_ext != '0) && (alloc_cnt_ff >= max_ext);

   always_comb begin
      max_alloc_in   = max_alloc_ff;
      general_cfg_in = general_cfg_ff;
      reserve_cfg_in = reserve_cfg_ff;
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      irq_in         = irq_ff;
      idx_in         = idx_ff;
      sweep_in       = sweep_ff;
      gen_head_in    = gen_head_ff;
      gen_tail_in    = gen_tail_ff;
      gen_cnt_in     = gen_cnt_ff;
      res_head_in    = res_head_ff;
      res_tail_in    = res_tail_ff;
      res_cnt_in     = res_cnt_ff;
      alloc_cnt_in   = alloc_cnt_ff;
      lat_reserve_in = lat_reserve_ff;
      lat_total_in   = lat_total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      link_we        = 1'b0;
      link_waddr     = sweep_ff;
      link_wdata     = sweep_ff - 1'b1;
      status         = ST_OK;
      granted        = '0;
      avail          = '0;

      if (csr_we) begin
         case (csr_addr)
            CSR_MAX_ALLOC:      max_alloc_in   = csr_wdata;
            CSR_GENERAL_BLOCKS: general_cfg_in = csr_wdata;
            CSR_RESERVE_BLOCKS: reserve_cfg_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in   = cmd_type'(req_tuser[1:0]);
               irq_in   = req_tuser[2];
               idx_in   = req_tdata[IDX_W-1:0];
               sweep_in = IDX_W'(1);
               state_in = (cmd_type'(req_tuser[1:0]) == CMD_INIT) ? S_SWEEP : S_FINISH;
            end
         end

         S_SWEEP: begin
            // Chain every block inside the pool to the one below it. The lowest block of
            // each region is its tail, and an init leaves the link of a tail and of every
            // block outside the pool as it was.
            link_we  = (CNT_W'(sweep_ff) < total_eff) && (CNT_W'(sweep_ff) != res_eff);
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_IDX) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (out_free) begin
               case (cmd_ff)
                  CMD_INIT: begin
                     res_cnt_in     = res_eff;
                     res_head_in    = (res_eff != '0) ? IDX_W'(res_eff - 1'b1) : '0;
                     res_tail_in    = '0;
                     gen_cnt_in     = gen_eff;
                     gen_head_in    = (gen_eff != '0) ? IDX_W'(total_eff - 1'b1) : '0;
                     gen_tail_in    = (gen_eff != '0) ? IDX_W'(res_eff) : '0;
                     alloc_cnt_in   = '0;
                     lat_reserve_in = res_eff;
                     lat_total_in   = total_eff;
                  end

                  CMD_ALLOC: begin
                     if (limited) begin
                        status = ST_LIMIT;
                     end else if (gen_cnt_ff != '0) begin
                        granted      = gen_head_ff;
                        gen_cnt_in   = gen_cnt_ff - 1'b1;
                        alloc_cnt_in = alloc_cnt_ff + 1'b1;
                        if (gen_cnt_ff > CNT_W'(1)) begin
                           gen_head_in = link_rdata;
                        end
                     end else if (irq_ff && (res_cnt_ff != '0)) begin
                        granted      = res_head_ff;
                        res_cnt_in   = res_cnt_ff - 1'b1;
                        alloc_cnt_in = alloc_cnt_ff + 1'b1;
                        if (res_cnt_ff > CNT_W'(1)) begin
                           res_head_in = link_rdata;
                        end
                     end else begin
                        status = ST_EMPTY;
                     end
                  end

                  CMD_RELEASE: begin
                     if ((alloc_cnt_ff == '0) || (CNT_W'(idx_ff) >= lat_total_ff)) begin
                        status = ST_BAD_RELEASE;
                     end else begin
                        alloc_cnt_in = alloc_cnt_ff - 1'b1;
                        link_wdata   = idx_ff;
                        if (CNT_W'(idx_ff) < lat_reserve_ff) begin
                           if (res_cnt_ff == '0) begin
                              res_head_in = idx_ff;
                           end else begin
                              link_we    = 1'b1;
                              link_waddr = res_tail_ff;
                           end
                           res_tail_in = idx_ff;
                           res_cnt_in  = res_cnt_ff + 1'b1;
                        end else begin
                           if (gen_cnt_ff == '0) begin
                              gen_head_in = idx_ff;
                           end else begin
                              link_we    = 1'b1;
                              link_waddr = gen_tail_ff;
                           end
                           gen_tail_in = idx_ff;
                           gen_cnt_in  = gen_cnt_ff + 1'b1;
                        end
                     end
                  end

                  default: ;
               endcase

               if ((max_ext != '0) && (max_ext > alloc_cnt_in)) begin
                  avail = max_ext - alloc_cnt_in;
               end

               rsp_valid_in = 1'b1;
               rsp_user_in  = status;
               rsp_data_in  = {3'b000, 9'(res_cnt_in), 9'(gen_cnt_in), 9'(alloc_cnt_in),
                               9'(avail), (max_ext == '0), 8'(granted)};
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_alloc_ff   <= '0;
         general_cfg_ff <= CFG_W'(256);
         reserve_cfg_ff <= '0;
         state_ff       <= S_IDLE;
         gen_head_ff    <= '0;
         gen_tail_ff    <= '0;
         gen_cnt_ff     <= '0;
         res_head_ff    <= '0;
         res_tail_ff    <= '0;
         res_cnt_ff     <= '0;
         alloc_cnt_ff   <= '0;
         lat_reserve_ff <= '0;
         lat_total_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_alloc_ff   <= max_alloc_in;
         general_cfg_ff <= general_cfg_in;
         reserve_cfg_ff <= reserve_cfg_in;
         state_ff       <= state_in;
         gen_head_ff    <= gen_head_in;
         gen_tail_ff    <= gen_tail_in;
         gen_cnt_ff     <= gen_cnt_in;
         res_head_ff    <= res_head_in;
         res_tail_ff    <= res_tail_in;
         res_cnt_ff     <= res_cnt_in;
         alloc_cnt_ff   <= alloc_cnt_in;
         lat_reserve_ff <= lat_reserve_in;
         lat_total_ff   <= lat_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      irq_ff      <= irq_in;
      idx_ff      <= idx_in;
      sweep_ff    <= sweep_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
